[hw/rtl/keyed_queue_lock_with_barriers_core_assert.svh]
// Assertion macros for the keyed queue lock core.
// Bodies expect signals named clk and rst in the using scope.
`ifndef KEYED_QUEUE_LOCK_WITH_BARRIERS_CORE_ASSERT_SVH
`define KEYED_QUEUE_LOCK_WITH_BARRIERS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define KQL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed queue lock: same-cycle check failed");

`define KQL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed queue lock: next-cycle check failed");

`else

`define KQL_ASSERT_SAME(label, ante, cons)

`define KQL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hw/rtl/kql_pkg.sv]
`default_nettype none

package kql_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int CTX_W   = 16;
  localparam int ERR_W   = 2;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 8;

  typedef enum logic [KIND_W-1:0] {
    OP_ACQUIRE    = 2'd0,
    OP_RELEASE    = 2'd1,
    OP_BAR_INSERT = 2'd2,
    OP_BAR_REMOVE = 2'd3
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_BUSY     = 2'd1,
    ERR_NOT_HELD = 2'd2,
    ERR_ZERO_CTX = 2'd3
  } err_t;

  typedef struct packed {
    err_t              error;
    logic [SLOT_W-1:0] wake_slot;
    logic              wake_valid;
    logic              granted;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/keyed_queue_lock_with_barriers_core.sv]
// Channel  Dir  tvalid/tready  tdata (low bit up)                          tuser
// s_axis   in   beat per op    slot[3:0], context_req[19:4], zero [23:20]  kind[1:0]
// m_axis   out  beat per op    granted[0], wake_valid[1], wake_slot[5:2],  -
//                              error[7:6]
// One result beat per input beat; a beat goes input register -> lock table
// update and result register, one beat per cycle while m_axis is not stalled.
// The lock table and result are written in the same cycle as the beat leaves
// the input register, so the next beat always sees the updated table.
// Reset clears the slot in-use bits and both stage valids; no clearing pass.
// A stalled m_axis holds the result and backs up into s_axis after one beat.
`default_nettype none

`include "keyed_queue_lock_with_barriers_core_assert.svh"

module keyed_queue_lock_with_barriers_core #(
  parameter int SLOTS    = kql_pkg::SLOTS_DEF,
  parameter int KEY_BITS = kql_pkg::KEY_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // slot[3:0], context_req[19:4], zero pad
  input  wire logic [kql_pkg::IN_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  wire logic [kql_pkg::KIND_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // granted, wake_valid, wake_slot[3:0], error[1:0]
  output logic [kql_pkg::OUT_W-1:0]      m_axis_tdata
);
  import kql_pkg::*;

  localparam int SW = $clog2(SLOTS);

  // input register
  logic              in_valid;
  op_t               in_kind;
  logic [SLOT_W-1:0] in_slot;
  logic [CTX_W-1:0]  in_ctx;

  // result register
  logic              out_valid;
  res_t              out_res;

  // lock table
  logic [SLOTS-1:0]    in_use, in_use_next;
  logic [SLOTS-1:0]    has_succ, has_succ_next;
  logic [SLOTS-1:0]    is_bar, is_bar_next;
  logic [SLOTS-1:0]    bar_fol, bar_fol_next;
  logic [SW-1:0]       succ [SLOTS];
  logic [SW-1:0]       succ_next [SLOTS];
  logic [KEY_BITS-1:0] key_tab [SLOTS];
  logic [KEY_BITS-1:0] key_tab_next [SLOTS];

  logic                fire;
  logic                out_free;
  logic                slot_ok;
  logic [SW-1:0]       s_idx;
  logic [KEY_BITS-1:0] key;
  logic                tail_found;
  logic [SW-1:0]       tail_idx;
  logic                pred_found;
  logic [SW-1:0]       pred_idx;
  logic [SW-1:0]       n_idx;
  logic                wake_s;
  logic                do_take;
  logic                take_bar;
  logic                do_free;
  logic                do_relink;
  res_t                res;

  assign out_free      = !out_valid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_res);

  assign slot_ok = (32'(in_slot) < SLOTS);
  assign s_idx   = SW'(in_slot);
  assign key     = KEY_BITS'(in_ctx);
  assign n_idx   = succ[s_idx];
  assign wake_s  = has_succ[s_idx] && (32'(n_idx) < SLOTS) &&
                   in_use[n_idx] && !is_bar[n_idx];

  // lowest-index tail of the requested key
  always_comb begin
    tail_found = 1'b0;
    tail_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (in_use[i] && key_tab[i] == key && !has_succ[i]) begin
        tail_found = 1'b1;
        tail_idx   = SW'(i);
      end
    end
  end

  // lowest-index predecessor of the addressed slot
  always_comb begin
    pred_found = 1'b0;
    pred_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (SW'(i) != s_idx && in_use[i] && has_succ[i] && succ[i] == s_idx) begin
        pred_found = 1'b1;
        pred_idx   = SW'(i);
      end
    end
  end

  // decode
  always_comb begin
    res       = '{error: ERR_OK, wake_slot: '0, wake_valid: 1'b0, granted: 1'b0};
    do_take   = 1'b0;
    take_bar  = 1'b0;
    do_free   = 1'b0;
    do_relink = 1'b0;
    if (!slot_ok) begin
      res.error = ERR_NOT_HELD;
    end else begin
      unique case (in_kind)
        OP_ACQUIRE: begin
          if (in_use[s_idx]) begin
            res.error = ERR_BUSY;
          end else if (key == '0) begin
            res.error = ERR_ZERO_CTX;
          end else begin
            res.granted = !tail_found;
            do_take     = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (!in_use[s_idx] || is_bar[s_idx]) begin
            res.error = ERR_NOT_HELD;
          end else begin
            res.wake_valid = wake_s;
            res.wake_slot  = wake_s ? SLOT_W'(n_idx) : '0;
            do_free        = 1'b1;
          end
        end
        OP_BAR_INSERT: begin
          if (in_use[s_idx]) begin
            res.error = ERR_BUSY;
          end else begin
            do_take  = 1'b1;
            take_bar = 1'b1;
          end
        end
        OP_BAR_REMOVE: begin
          if (!in_use[s_idx] || !is_bar[s_idx]) begin
            res.error = ERR_NOT_HELD;
          end else begin
            do_free = 1'b1;
            if (pred_found) begin
              do_relink = 1'b1;
            end else begin
              res.wake_valid = wake_s;
              res.wake_slot  = wake_s ? SLOT_W'(n_idx) : '0;
            end
          end
        end
        default: res.error = ERR_NOT_HELD;
      endcase
    end
  end

  // table update
  always_comb begin
    in_use_next   = in_use;
    has_succ_next = has_succ;
    is_bar_next   = is_bar;
    bar_fol_next  = bar_fol;
    succ_next     = succ;
    key_tab_next  = key_tab;
    if (do_take) begin
      if (tail_found) begin
        succ_next[tail_idx]     = s_idx;
        has_succ_next[tail_idx] = 1'b1;
        if (take_bar) begin
          bar_fol_next[tail_idx] = 1'b1;
        end
      end
      in_use_next[s_idx]   = 1'b1;
      key_tab_next[s_idx]  = key;
      has_succ_next[s_idx] = 1'b0;
      succ_next[s_idx]     = '0;
      is_bar_next[s_idx]   = take_bar;
      bar_fol_next[s_idx]  = 1'b0;
    end
    if (do_relink) begin
      succ_next[pred_idx]     = succ[s_idx];
      has_succ_next[pred_idx] = has_succ[s_idx];
      if (bar_fol[s_idx]) begin
        bar_fol_next[pred_idx] = 1'b1;
      end
    end
    if (do_free) begin
      in_use_next[s_idx] = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (in_use_next[i] && has_succ_next[i] && succ_next[i] == s_idx) begin
          has_succ_next[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      in_use    <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (fire) begin
        out_valid <= 1'b1;
        in_use    <= in_use_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= op_t'(s_axis_tuser);
      in_slot <= s_axis_tdata[SLOT_W-1:0];
      in_ctx  <= s_axis_tdata[SLOT_W +: CTX_W];
    end
    if (fire) begin
      out_res  <= res;
      has_succ <= has_succ_next;
      is_bar   <= is_bar_next;
      bar_fol  <= bar_fol_next;
      succ     <= succ_next;
      key_tab  <= key_tab_next;
    end
  end

  `KQL_ASSERT_SAME(a_err_clean, fire && res.error != ERR_OK, !res.granted && !res.wake_valid && res.wake_slot == '0 && !do_take && !do_free)
  `KQL_ASSERT_SAME(a_grant_no_wake, fire && res.granted, !res.wake_valid && in_kind == OP_ACQUIRE)
  `KQL_ASSERT_NEXT(a_woken_held, fire && res.wake_valid, in_use[$past(n_idx)])
  `KQL_ASSERT_NEXT(a_taken_held, fire && do_take, in_use[$past(s_idx)])
  `KQL_ASSERT_NEXT(a_freed_clear, fire && do_free, !in_use[$past(s_idx)])

endmodule

`default_nettype wire
